[src/playfair_digraph_cipher_unit_macros.svh]
// Assertion macros shared by the cipher unit's modules.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_UNIT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_UNIT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdc: assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define PDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdc: assertion failed");

`endif

[src/pdc_pkg.sv]
`timescale 1ns / 1ps

package pdc_pkg;

	localparam int GRID_W   = 5;
	localparam int IDX_W    = $clog2(GRID_W);
	localparam int LETTER_W = 5;

	localparam logic [LETTER_W-1:0] LET_I = 5'd8;
	localparam logic [LETTER_W-1:0] LET_J = 5'd9;
	localparam logic [LETTER_W-1:0] LET_Q = 5'd16;
	localparam logic [LETTER_W-1:0] LET_X = 5'd23;
	localparam logic [LETTER_W-1:0] LET_Z = 5'd25;

	typedef enum logic [2:0] {
		REG_GRID_ROW0 = 3'd0,
		REG_GRID_ROW1 = 3'd1,
		REG_GRID_ROW2 = 3'd2,
		REG_GRID_ROW3 = 3'd3,
		REG_GRID_ROW4 = 3'd4,
		REG_DIRECTION = 3'd5
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISSING  = 2'd1,
		ST_UNPAIRED = 2'd2
	} status_t;

	// Row-major key grid: grid[row][col] is one letter code.
	typedef logic [GRID_W-1:0][GRID_W-1:0][LETTER_W-1:0] grid_t;

	// One pair to substitute, or an unpaired trailing letter to report.
	typedef struct packed {
		logic [LETTER_W-1:0] a;
		logic [LETTER_W-1:0] b;
		logic                dec;
		logic                unpaired;
		logic                run_last;
		logic                text_last;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_req_t;

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                run_last;
		logic                text_last;
		status_t             status;
	} word_t;

endpackage

[src/pdc_front.sv]
`timescale 1ns / 1ps

module pdc_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     direction,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [pdc_pkg::LETTER_W-1:0] letter_in,
	input  logic                     end_of_text,
	input  logic                     q_full,
	output pdc_pkg::job_req_t        push
);
	import pdc_pkg::*;

	logic [LETTER_W-1:0] pend_q;
	logic                pend_valid_q;
	job_t                extra_q;
	logic                extra_valid_q;

	logic [LETTER_W-1:0] letter;
	logic                has_a, has_b;
	job_t                job_a, job_b;
	logic                accept;
	logic                next_pend_valid;

	assign letter = (letter_in == LET_J) ? LET_I : letter_in;

	// Sort the incoming letter into zero, one or two pair jobs.
	always_comb begin
		has_a = 1'b0;
		has_b = 1'b0;
		job_a = '{a: pend_q, b: letter, dec: direction, unpaired: 1'b0,
			run_last: 1'b1, text_last: end_of_text};
		job_b = '{a: letter, b: LET_Z, dec: 1'b0, unpaired: 1'b0,
			run_last: 1'b1, text_last: end_of_text};
		if (direction) begin
			if (pend_valid_q) begin
				has_a = 1'b1;
			end else if (end_of_text) begin
				has_a = 1'b1;
				job_a.a = '0;
				job_a.b = '0;
				job_a.unpaired = 1'b1;
			end
		end else begin
			if (pend_valid_q && pend_q != letter) begin
				has_a = 1'b1;
			end else if (pend_valid_q) begin
				has_a = 1'b1;
				job_a.b = (pend_q == LET_X) ? LET_Q : LET_X;
				if (end_of_text) begin
					has_b = 1'b1;
					job_a.run_last = 1'b0;
					job_a.text_last = 1'b0;
				end
			end else if (end_of_text) begin
				has_a = 1'b1;
				job_a.a = letter;
				job_a.b = LET_Z;
			end
		end
	end

	always_comb begin
		if (direction) begin
			next_pend_valid = !pend_valid_q && !end_of_text;
		end else if (pend_valid_q && pend_q != letter) begin
			next_pend_valid = 1'b0;
		end else begin
			next_pend_valid = !end_of_text;
		end
	end

	assign s_tready   = !extra_valid_q && !q_full;
	assign accept     = s_tvalid && s_tready;
	assign push.valid = !q_full && (extra_valid_q || (s_tvalid && has_a));
	assign push.job   = extra_valid_q ? extra_q : job_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q  <= 1'b0;
			pend_q        <= '0;
			extra_valid_q <= 1'b0;
		end else begin
			if (extra_valid_q && !q_full) begin
				extra_valid_q <= 1'b0;
			end
			if (accept) begin
				pend_valid_q <= next_pend_valid;
				if (next_pend_valid) begin
					pend_q <= letter;
				end
				if (has_b) begin
					extra_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_b) begin
			extra_q <= job_b;
		end
	end

endmodule

[src/pdc_queue.sv]
`timescale 1ns / 1ps
`include "playfair_digraph_cipher_unit_macros.svh"

module pdc_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pdc_pkg::job_req_t push,
	output logic              full,
	output pdc_pkg::job_req_t head,
	input  logic              pop
);
	import pdc_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push.valid) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.job;
		end
	end

	`PDC_ASSERT_NOW(a_no_push_full, clk, arst_n, push.valid, count_q != CNT_W'(DEPTH))
	`PDC_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, count_q != '0)
	`PDC_ASSERT_NEXT(a_count_tracks, clk, arst_n, 1'b1,
		count_q == $past(count_q) + CNT_W'($past(push.valid)) - CNT_W'($past(pop)))

endmodule

[src/pdc_back.sv]
`timescale 1ns / 1ps
`include "playfair_digraph_cipher_unit_macros.svh"

module pdc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pdc_pkg::grid_t    grid,
	input  pdc_pkg::job_req_t head,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output pdc_pkg::word_t    m_word
);
	import pdc_pkg::*;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} loc_t;

	// Grid position of a letter; the first match in row-major order wins.
	function automatic loc_t locate(input grid_t g, input logic [LETTER_W-1:0] code);
		loc_t res;
		res = '0;
		for (int r = GRID_W - 1; r >= 0; r--) begin
			for (int c = GRID_W - 1; c >= 0; c--) begin
				if (g[r][c] == code && code <= LET_Z) begin
					res.found = 1'b1;
					res.row   = IDX_W'(r);
					res.col   = IDX_W'(c);
				end
			end
		end
		return res;
	endfunction

	function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] x, input logic dec);
		logic [IDX_W-1:0] res;
		if (dec) begin
			res = (x == '0) ? IDX_W'(GRID_W - 1) : x - 1'b1;
		end else begin
			res = (x == IDX_W'(GRID_W - 1)) ? '0 : x + 1'b1;
		end
		return res;
	endfunction

	// Stage 1: grid positions of both letters.
	job_t job_s1;
	loc_t loc_a_s1, loc_b_s1;
	logic valid_s1;

	// Output register: one or two words of the current job.
	word_t w0_q, w1_q;
	logic  ob_valid_q, two_q, sel_q;

	logic             ob_take, ob_last, ob_free, load, s1_free;
	word_t            w0_d, w1_d;
	logic [IDX_W-1:0] nr_a, nc_a, nr_b, nc_b;

	assign ob_last = !two_q || sel_q;
	assign ob_take = ob_valid_q && m_tready;
	assign ob_free = !ob_valid_q || (ob_take && ob_last);
	assign load    = valid_s1 && ob_free;
	assign s1_free = !valid_s1 || load;
	assign pop     = head.valid && s1_free;

	assign m_tvalid = ob_valid_q;
	assign m_word   = sel_q ? w1_q : w0_q;

	always_comb begin
		nr_a = loc_a_s1.row;
		nc_a = loc_a_s1.col;
		nr_b = loc_b_s1.row;
		nc_b = loc_b_s1.col;
		if (loc_a_s1.row == loc_b_s1.row) begin
			nc_a = step_idx(loc_a_s1.col, job_s1.dec);
			nc_b = step_idx(loc_b_s1.col, job_s1.dec);
		end else if (loc_a_s1.col == loc_b_s1.col) begin
			nr_a = step_idx(loc_a_s1.row, job_s1.dec);
			nr_b = step_idx(loc_b_s1.row, job_s1.dec);
		end else begin
			nc_a = loc_b_s1.col;
			nc_b = loc_a_s1.col;
		end
	end

	always_comb begin
		w0_d = '{letter: grid[nr_a][nc_a], run_last: 1'b0, text_last: 1'b0, status: ST_OK};
		w1_d = '{letter: grid[nr_b][nc_b], run_last: job_s1.run_last,
			text_last: job_s1.text_last, status: ST_OK};
		if (job_s1.unpaired) begin
			w0_d = '{letter: '0, run_last: job_s1.run_last,
				text_last: job_s1.text_last, status: ST_UNPAIRED};
		end else if (!(loc_a_s1.found && loc_b_s1.found)) begin
			w0_d.letter = job_s1.a;
			w0_d.status = ST_MISSING;
			w1_d.letter = job_s1.b;
			w1_d.status = ST_MISSING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			ob_valid_q <= 1'b0;
			sel_q      <= 1'b0;
			two_q      <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= head.valid;
			end
			if (load) begin
				ob_valid_q <= 1'b1;
				sel_q      <= 1'b0;
				two_q      <= !job_s1.unpaired;
			end else if (ob_take) begin
				if (ob_last) begin
					ob_valid_q <= 1'b0;
				end else begin
					sel_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_s1   <= head.job;
			loc_a_s1 <= locate(grid, head.job.a);
			loc_b_s1 <= locate(grid, head.job.b);
		end
		if (load) begin
			w0_q <= w0_d;
			w1_q <= w1_d;
		end
	end

	`PDC_ASSERT_NEXT(a_drain_empties, clk, arst_n, ob_take && ob_last && !load, !ob_valid_q)
	`PDC_ASSERT_NOW(a_single_is_unpaired, clk, arst_n, ob_valid_q && !two_q,
		w0_q.status == ST_UNPAIRED)
	`PDC_ASSERT_NOW(a_unpaired_form, clk, arst_n, ob_valid_q && w0_q.status == ST_UNPAIRED,
		w0_q.letter == '0 && w0_q.run_last && !two_q)

endmodule

[src/playfair_digraph_cipher_unit.sv]
`timescale 1ns / 1ps

// Playfair digraph cipher unit. Letters (0 = A through 25 = Z) stream in on the
// slave side, one word per cycle; J is read as I and letters are paired. When
// encrypting, a doubled letter gets X (Q after X) and an odd tail is padded
// with Z; when decrypting, a lone last letter yields one word with letter 0
// and status "unpaired". Each pair becomes two substituted words on the
// master side, carrying a status of "letter not in grid" when either letter
// is missing, in which case the letters pass through unchanged. Rate: an
// input word can be taken every cycle while the pair queue has room. An
// encrypt doubled letter arriving with end of text makes two pairs and holds
// the input while the front end queues the second pair. The output side
// moves at most one word per cycle, set by the master port and the two-word
// output register, so a sustained run gives one result word per cycle; when
// the input produces words faster than that (filler pairs, Z padding, or a
// stalled master port) the queue fills and the input is held until it
// drains. A pair's first word is presented once the word closing it has
// passed the pair queue (written at the edge that accepts that word), the
// grid lookup stage and the output register. Load the five grid rows
// and the direction through the write port while the unit is idle; writes
// take effect at once, there is no read-back, and indexes past the direction
// register are ignored. The grid resets to all zero and needs no clearing.
module playfair_digraph_cipher_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input word.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [4:0] letter_code, [7:5] zero
	input  logic        s_tlast,   // end_of_text
	// Result word.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [4:0] cipher_letter, [5] run_last, [7:6] zero
	output logic        m_tlast,   // text_last
	output logic [1:0]  m_tuser,   // [1:0] status
	// Configuration writes.
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [24:0] cfg_data
);
	import pdc_pkg::*;

	grid_t    grid_q;
	logic     direction_q;
	job_req_t push;
	job_req_t head;
	logic     q_full;
	logic     pop;
	word_t    word;

	// Configuration registers, indexed in the order of the register list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q      <= '0;
			direction_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GRID_ROW0: grid_q[0] <= cfg_data;
				REG_GRID_ROW1: grid_q[1] <= cfg_data;
				REG_GRID_ROW2: grid_q[2] <= cfg_data;
				REG_GRID_ROW3: grid_q[3] <= cfg_data;
				REG_GRID_ROW4: grid_q[4] <= cfg_data;
				REG_DIRECTION: direction_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Front end: pairing, digraph fixing and queueing of pair jobs.
	pdc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.direction  (direction_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.letter_in  (s_tdata[4:0]),
		.end_of_text(s_tlast),
		.q_full     (q_full),
		.push       (push)
	);

	// Short queue that lets the two halves stall independently.
	pdc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (q_full),
		.head  (head),
		.pop   (pop)
	);

	// Back end: grid lookup, substitution and result words.
	pdc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.grid    (grid_q),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_word  (word)
	);

	assign m_tdata = {2'b00, word.run_last, word.letter};
	assign m_tlast = word.text_last;
	assign m_tuser = word.status;

endmodule
